/* src/hybrid_branch_predictor_assert.svh */
`ifndef HYBRID_BRANCH_PREDICTOR_ASSERT_SVH
`define HYBRID_BRANCH_PREDICTOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define HBP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define HBP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/hbp_pkg.sv */
package hbp_pkg;

    localparam int ADDR_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;
    localparam int CNT_W      = 32;

    typedef logic [1:0]            t_ctr;
    typedef logic [3:0]            t_bits;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_BIMODAL    = 2'd0,
        MODE_GSHARE     = 2'd1,
        MODE_HYBRID     = 2'd2,
        MODE_HYBRID_ALT = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    localparam t_cfg_idx REG_MODE         = 3'd0;
    localparam t_cfg_idx REG_GSHARE_BITS  = 3'd1;
    localparam t_cfg_idx REG_HISTORY_BITS = 3'd2;
    localparam t_cfg_idx REG_BIMODAL_BITS = 3'd3;
    localparam t_cfg_idx REG_CHOOSER_BITS = 3'd4;

    localparam t_mode MODE_RESET         = MODE_BIMODAL;
    localparam t_bits GSHARE_BITS_RESET  = 4'd12;
    localparam t_bits HISTORY_BITS_RESET = 4'd8;
    localparam t_bits BIMODAL_BITS_RESET = 4'd12;
    localparam t_bits CHOOSER_BITS_RESET = 4'd12;

    localparam t_ctr CTR_RESET     = 2'd2;
    localparam t_ctr CHOOSER_RESET = 2'd1;
    localparam t_ctr CTR_MAX       = 2'd3;
    localparam t_ctr CTR_MIN       = 2'd0;

    typedef struct packed {
        logic [ADDR_W-1:0] branch_address;
        logic              taken;
    } t_in;

    typedef struct packed {
        logic             predicted_taken;
        logic             mispredicted;
        logic             used_gshare;
        logic [CNT_W-1:0] prediction_total;
        logic [CNT_W-1:0] mispredict_total;
    } t_out;

    // 2-bit saturating counter step
    function automatic t_ctr f_train(input t_ctr ctr, input logic up);
        t_ctr res;
        if (up) begin
            res = (ctr == CTR_MAX) ? CTR_MAX : ctr + 2'd1;
        end else begin
            res = (ctr == CTR_MIN) ? CTR_MIN : ctr - 2'd1;
        end
        return res;
    endfunction

endpackage

/* src/hybrid_branch_predictor.sv */
// a result is registered in the lookup state that follows acceptance of its branch
// beat; that state holds while the result register is blocked, and a new branch is
// taken only when idle, after the read-modify-write round trip through the three
// single-read-port counter memories and the global history has committed
// reset (synchronous, active low): a clearing pass writes every table entry; no
// branch is taken meanwhile, configuration writes are taken throughout
module hybrid_branch_predictor #(
    parameter int MAX_INDEX_BITS = 12,
    parameter int ADDRESS_WIDTH  = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  hbp_pkg::t_in                 i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output hbp_pkg::t_out                o_out_data,
    input  logic                         i_cfg_we,
    input  hbp_pkg::t_cfg_idx            i_cfg_idx,
    input  logic [hbp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import hbp_pkg::*;

    localparam int IW = MAX_INDEX_BITS;

    function automatic logic [IW-1:0] f_mask(input t_bits bits);
        logic [IW-1:0] m;
        for (int i = 0; i < IW; i++) begin
            m[i] = (i < int'(bits));
        end
        return m;
    endfunction

    // word index bits, with address bits at or above ADDRESS_WIDTH reading as zero
    function automatic logic [IW-1:0] f_word(input logic [ADDR_W-1:0] addr);
        logic [ADDR_W+IW+1:0] ext;
        logic [IW-1:0]        w;
        ext = {{(IW+2){1'b0}}, addr};
        for (int i = 0; i < IW; i++) begin
            w[i] = ext[i+2] & ((i + 2) < ADDRESS_WIDTH);
        end
        return w;
    endfunction

    t_state r_state, n_state;
    t_mode  r_mode;
    t_bits  r_gbits, r_hbits, r_bbits, r_cbits;

    logic [IW-1:0] r_clr_addr;
    logic [IW-1:0] r_hist;
    logic [IW-1:0] r_bidx, r_gidx, r_cidx;
    logic          r_taken;
    logic [CNT_W-1:0] r_pred_cnt, r_miss_cnt;
    logic [CNT_W-1:0] n_pred_cnt, n_miss_cnt;
    logic          r_out_valid;
    t_out          r_out_data;

    logic          w_accept, w_commit, w_clearing;
    logic [IW-1:0] w_gmask, w_hmask, w_bmask, w_cmask, w_word;
    logic [IW-1:0] w_bidx_in, w_gidx_in, w_cidx_in;
    logic [IW-1:0] w_b_raddr, w_g_raddr, w_c_raddr;
    logic [IW-1:0] w_b_waddr, w_g_waddr, w_c_waddr;
    t_ctr          w_bctr, w_gctr, w_cctr;
    t_ctr          w_b_wdata, w_g_wdata, w_c_wdata;
    logic          w_b_we, w_g_we, w_c_we;
    logic          w_hybrid, w_use_g, w_bpred, w_gpred, w_pred, w_miss;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_RESET;
            r_gbits <= GSHARE_BITS_RESET;
            r_hbits <= HISTORY_BITS_RESET;
            r_bbits <= BIMODAL_BITS_RESET;
            r_cbits <= CHOOSER_BITS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MODE:         r_mode  <= t_mode'(i_cfg_data[1:0]);
                REG_GSHARE_BITS:  r_gbits <= i_cfg_data;
                REG_HISTORY_BITS: r_hbits <= i_cfg_data;
                REG_BIMODAL_BITS: r_bbits <= i_cfg_data;
                REG_CHOOSER_BITS: r_cbits <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // index generation
    always_comb begin
        w_gmask   = f_mask(r_gbits);
        w_hmask   = f_mask(r_hbits) & w_gmask;
        w_bmask   = f_mask(r_bbits);
        w_cmask   = f_mask(r_cbits);
        w_word    = f_word(i_in_data.branch_address);
        w_bidx_in = w_word & w_bmask;
        w_gidx_in = (w_word ^ (r_hist & w_hmask)) & w_gmask;
        w_cidx_in = w_word & w_cmask;
    end

    // state machine
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:  if (&r_clr_addr) n_state = ST_IDLE;
            ST_IDLE:   if (i_in_valid) n_state = ST_LOOKUP;
            ST_LOOKUP: if (!r_out_valid || !i_out_stall) n_state = ST_IDLE;
            default:   n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        w_commit   = 1'b0;
        w_clearing = 1'b0;
        unique case (r_state)
            ST_CLEAR:  w_clearing = 1'b1;
            ST_IDLE:   o_in_stall = 1'b0;
            ST_LOOKUP: w_commit   = !r_out_valid || !i_out_stall;
            default:   w_clearing = 1'b0;
        endcase
    end

    assign w_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (w_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_bidx  <= w_bidx_in;
            r_gidx  <= w_gidx_in;
            r_cidx  <= w_cidx_in;
            r_taken <= i_in_data.taken;
        end
    end

    // the lookup state keeps re-reading the held indices so the read data stays
    // valid for as long as the result register is blocked
    assign w_b_raddr = (r_state == ST_IDLE) ? w_bidx_in : r_bidx;
    assign w_g_raddr = (r_state == ST_IDLE) ? w_gidx_in : r_gidx;
    assign w_c_raddr = (r_state == ST_IDLE) ? w_cidx_in : r_cidx;

    // prediction and training
    always_comb begin
        w_hybrid = (r_mode == MODE_HYBRID) || (r_mode == MODE_HYBRID_ALT);
        w_bpred  = w_bctr[1];
        w_gpred  = w_gctr[1];
        w_use_g  = w_hybrid ? w_cctr[1] : (r_mode == MODE_GSHARE);
        w_pred   = w_use_g ? w_gpred : w_bpred;
        w_miss   = w_pred != r_taken;
    end

    always_comb begin
        if (w_clearing) begin
            w_b_we    = 1'b1;
            w_g_we    = 1'b1;
            w_c_we    = 1'b1;
            w_b_waddr = r_clr_addr;
            w_g_waddr = r_clr_addr;
            w_c_waddr = r_clr_addr;
            w_b_wdata = CTR_RESET;
            w_g_wdata = CTR_RESET;
            w_c_wdata = CHOOSER_RESET;
        end else begin
            w_b_we    = w_commit && !w_use_g;
            w_g_we    = w_commit && w_use_g;
            // chooser moves only when exactly one predictor was right
            w_c_we    = w_commit && w_hybrid && (w_bpred != w_gpred);
            w_b_waddr = r_bidx;
            w_g_waddr = r_gidx;
            w_c_waddr = r_cidx;
            w_b_wdata = f_train(w_bctr, r_taken);
            w_g_wdata = f_train(w_gctr, r_taken);
            w_c_wdata = f_train(w_cctr, w_gpred == r_taken);
        end
    end

    hbp_table #(.IDX_BITS(IW)) u_bimodal (
        .i_clk   (i_clk),
        .i_we    (w_b_we),
        .i_waddr (w_b_waddr),
        .i_wdata (w_b_wdata),
        .i_raddr (w_b_raddr),
        .o_rdata (w_bctr)
    );

    hbp_table #(.IDX_BITS(IW)) u_gshare (
        .i_clk   (i_clk),
        .i_we    (w_g_we),
        .i_waddr (w_g_waddr),
        .i_wdata (w_g_wdata),
        .i_raddr (w_g_raddr),
        .o_rdata (w_gctr)
    );

    hbp_table #(.IDX_BITS(IW)) u_chooser (
        .i_clk   (i_clk),
        .i_we    (w_c_we),
        .i_waddr (w_c_waddr),
        .i_wdata (w_c_wdata),
        .i_raddr (w_c_raddr),
        .o_rdata (w_cctr)
    );

    // history and running totals
    assign n_pred_cnt = (r_pred_cnt == '1) ? r_pred_cnt : r_pred_cnt + 1'b1;
    assign n_miss_cnt = (!w_miss || r_miss_cnt == '1) ? r_miss_cnt : r_miss_cnt + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist     <= '0;
            r_pred_cnt <= '0;
            r_miss_cnt <= '0;
        end else if (w_commit) begin
            if (w_hybrid || w_use_g) begin
                r_hist <= {r_hist[IW-2:0], r_taken} & w_hmask;
            end
            r_pred_cnt <= n_pred_cnt;
            r_miss_cnt <= n_miss_cnt;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_data.predicted_taken  <= w_pred;
            r_out_data.mispredicted     <= w_miss;
            r_out_data.used_gshare      <= w_use_g;
            r_out_data.prediction_total <= n_pred_cnt;
            r_out_data.mispredict_total <= n_miss_cnt;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`include "hybrid_branch_predictor_assert.svh"

    `HBP_ASSERT_NOW(a_miss_le_pred, 1'b1, r_miss_cnt <= r_pred_cnt,
                    "mispredict total above branch total")
    `HBP_ASSERT_NOW(a_bimodal_no_gshare, r_out_valid && (r_mode == MODE_BIMODAL),
                    !r_out_data.used_gshare, "gshare reported in bimodal mode")
    `HBP_ASSERT_NEXT(a_count_step, w_commit && (r_pred_cnt != '1),
                     r_pred_cnt == $past(r_pred_cnt) + 1'b1,
                     "branch total did not advance on commit")

endmodule

/* src/hbp_table.sv */
module hbp_table #(
    parameter int IDX_BITS = 12
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [IDX_BITS-1:0] i_waddr,
    input  hbp_pkg::t_ctr       i_wdata,
    input  logic [IDX_BITS-1:0] i_raddr,
    output hbp_pkg::t_ctr       o_rdata
);
    import hbp_pkg::*;

    localparam int DEPTH = 1 << IDX_BITS;

    t_ctr r_mem [DEPTH];
    t_ctr r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sim/hybrid_branch_predictor_tb.sv */
`timescale 1ns / 1ps

import hbp_pkg::*;

class hbp_scoreboard;
    localparam int DEPTH = 4096;

    t_ctr        bim_ctr[DEPTH];
    t_ctr        gsh_ctr[DEPTH];
    t_ctr        cho_ctr[DEPTH];
    logic [11:0] ghist;
    logic [31:0] n_pred;
    logic [31:0] n_miss;
    t_mode       mode_r;
    t_bits       g_bits;
    t_bits       h_bits;
    t_bits       b_bits;
    t_bits       c_bits;
    t_out        expected_q[$];
    int          errors;

    function new();
        foreach (bim_ctr[i]) begin
            bim_ctr[i] = CTR_RESET;
            gsh_ctr[i] = CTR_RESET;
            cho_ctr[i] = CHOOSER_RESET;
        end
        ghist  = '0;
        n_pred = '0;
        n_miss = '0;
        mode_r = MODE_RESET;
        g_bits = GSHARE_BITS_RESET;
        h_bits = HISTORY_BITS_RESET;
        b_bits = BIMODAL_BITS_RESET;
        c_bits = CHOOSER_BITS_RESET;
        errors = 0;
    endfunction

    function int clamp_width(t_bits bits);
        return (bits > 12) ? 12 : int'(bits);
    endfunction

    function logic [11:0] low_ones(int n);
        return 12'((32'd1 << n) - 1);
    endfunction

    function t_ctr bump(t_ctr c, logic up);
        if (up) begin
            return (c == CTR_MAX) ? c : c + 2'd1;
        end
        return (c == CTR_MIN) ? c : c - 2'd1;
    endfunction

    function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_MODE:         mode_r = t_mode'(d[1:0]);
            REG_GSHARE_BITS:  g_bits = d;
            REG_HISTORY_BITS: h_bits = d;
            REG_BIMODAL_BITS: b_bits = d;
            REG_CHOOSER_BITS: c_bits = d;
            default: ;
        endcase
    endfunction

    function void predict_branch(t_in br);
        logic [11:0] word;
        logic [11:0] hmask;
        logic [11:0] bidx;
        logic [11:0] gidx;
        logic [11:0] cidx;
        int          g_n;
        int          h_n;
        logic        bpred;
        logic        gpred;
        logic        hybrid;
        logic        use_g;
        logic        pred;
        t_out        want;
        word = br.branch_address[13:2];
        g_n  = clamp_width(g_bits);
        h_n  = clamp_width(h_bits);
        if (h_n > g_n) h_n = g_n;
        hmask = low_ones(h_n);
        bidx  = word & low_ones(clamp_width(b_bits));
        gidx  = (word ^ (ghist & hmask)) & low_ones(g_n);
        cidx  = word & low_ones(clamp_width(c_bits));
        // upper counter bit is the direction
        bpred  = bim_ctr[bidx][1];
        gpred  = gsh_ctr[gidx][1];
        hybrid = (mode_r == MODE_HYBRID) || (mode_r == MODE_HYBRID_ALT);
        use_g  = hybrid ? cho_ctr[cidx][1] : (mode_r == MODE_GSHARE);
        pred   = use_g ? gpred : bpred;
        if (use_g) begin
            gsh_ctr[gidx] = bump(gsh_ctr[gidx], br.taken);
        end else begin
            bim_ctr[bidx] = bump(bim_ctr[bidx], br.taken);
        end
        if (use_g || hybrid) ghist = {ghist[10:0], br.taken} & hmask;
        // tables disagree: exactly one was right, lean the chooser towards it
        if (hybrid && gpred != bpred) cho_ctr[cidx] = bump(cho_ctr[cidx], gpred == br.taken);
        if (n_pred != '1) n_pred++;
        if (pred != br.taken && n_miss != '1) n_miss++;
        want.predicted_taken  = pred;
        want.mispredicted     = pred != br.taken;
        want.used_gshare      = use_g;
        want.prediction_total = n_pred;
        want.mispredict_total = n_miss;
        expected_q.push_back(want);
    endfunction

    function void check_result(t_out got);
        t_out want;
        if (expected_q.size() == 0) begin
            $error("result beat with no prediction outstanding");
            errors++;
            return;
        end
        want = expected_q.pop_front();
        if (got.predicted_taken !== want.predicted_taken) begin
            $error("predicted_taken: expected %0d, got %0d", want.predicted_taken,
                   got.predicted_taken);
            errors++;
        end
        if (got.mispredicted !== want.mispredicted) begin
            $error("mispredicted: expected %0d, got %0d", want.mispredicted, got.mispredicted);
            errors++;
        end
        if (got.used_gshare !== want.used_gshare) begin
            $error("used_gshare: expected %0d, got %0d", want.used_gshare, got.used_gshare);
            errors++;
        end
        if (got.prediction_total !== want.prediction_total) begin
            $error("prediction_total: expected %0d, got %0d", want.prediction_total,
                   got.prediction_total);
            errors++;
        end
        if (got.mispredict_total !== want.mispredict_total) begin
            $error("mispredict_total: expected %0d, got %0d", want.mispredict_total,
                   got.mispredict_total);
            errors++;
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module hybrid_branch_predictor_tb;
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in                   i_in_data   = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out                  o_out_data;
    logic                  i_cfg_we    = 1'b0;
    t_cfg_idx              i_cfg_idx   = REG_MODE;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_cycles   = 0;
    int send_pct_by_profile[4] = '{0, 60, 0, 16};
    int stall_pct_by_profile[4] = '{0, 0, 60, 16};

    logic [31:0] hot_pc[8];
    int          hot_bias[8];
    int          hot_period[8];
    int          hot_iter[8];

    hbp_scoreboard sb;

    hybrid_branch_predictor uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // receiver: a long hold-off when asked, random stalls otherwise
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles = hold_cycles - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) sb.set_reg(i_cfg_idx, i_cfg_data);
            if (o_out_valid === 1'b1 && !i_out_stall) sb.check_result(o_out_data);
            if (i_in_valid && o_in_stall === 1'b0) sb.predict_branch(i_in_data);
        end
    end

    task automatic send_branch(input t_in br);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= br;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] d);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
    endtask

    task automatic apply_setting(input t_mode m, input t_bits gb, input t_bits hb,
                                 input t_bits bb, input t_bits cb);
        // upper bits of the mode write are don't-care
        write_reg(REG_MODE, {2'($urandom_range(3)), m});
        write_reg(REG_GSHARE_BITS, gb);
        write_reg(REG_HISTORY_BITS, hb);
        write_reg(REG_BIMODAL_BITS, bb);
        write_reg(REG_CHOOSER_BITS, cb);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        t_in br;
        int  ph;
        int  n;
        int  j;
        int  k;
        sb = new();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: counters saturate both ways, low address bits ignored
        send_branch('{32'h0000_0000, 1'b1});
        send_branch('{32'h0000_0000, 1'b1});
        send_branch('{32'h0000_0000, 1'b1});
        send_branch('{32'hFFFF_FFFF, 1'b0});
        send_branch('{32'hFFFF_FFFF, 1'b0});
        send_branch('{32'hFFFF_FFFF, 1'b0});
        send_branch('{32'h0000_0003, 1'b0});

        // the unused mode value, oversized widths and a zero-width bimodal table
        drain();
        apply_setting(MODE_HYBRID_ALT, 4'd15, 4'd15, 4'd0, 4'd13);
        send_branch('{32'hFFFF_FFFC, 1'b1});
        send_branch('{32'h0000_0004, 1'b0});
        send_branch('{32'hAAAA_AAA8, 1'b1});
        send_branch('{32'h5555_5554, 1'b0});
        send_branch('{32'h0000_0000, 1'b1});
        send_branch('{32'h0000_0000, 1'b1});

        // history longer than the gshare index
        drain();
        apply_setting(MODE_GSHARE, 4'd1, 4'd12, 4'd12, 4'd0);
        send_branch('{32'h0000_0008, 1'b1});
        send_branch('{32'h0000_0008, 1'b0});
        send_branch('{32'h0000_000C, 1'b1});
        send_branch('{32'h0000_000C, 1'b1});

        // hybrid with no history: one branch pulls the chooser about
        drain();
        apply_setting(MODE_HYBRID, 4'd12, 4'd0, 4'd1, 4'd12);
        send_branch('{32'h0000_0100, 1'b1});
        send_branch('{32'h0000_0100, 1'b1});
        send_branch('{32'h0000_0100, 1'b0});
        send_branch('{32'h0000_0100, 1'b1});
        send_branch('{32'h0000_0100, 1'b0});
        send_branch('{32'h0000_0100, 1'b0});

        for (ph = 0; ph < 8; ph++) begin
            drain();
            case (ph)
                0: apply_setting(MODE_HYBRID_ALT, 4'd15, 4'd15, 4'd15, 4'd15);
                1: apply_setting(MODE_GSHARE, 4'd0, 4'd0, 4'd0, 4'd0);
                2: apply_setting(MODE_HYBRID, 4'd12, 4'd12, 4'd12, 4'd12);
                3: apply_setting(MODE_BIMODAL, 4'd1, 4'd1, 4'd1, 4'd1);
                4: apply_setting(MODE_HYBRID, 4'd2, 4'd6, 4'd1, 4'd3);
                default: apply_setting(t_mode'($urandom_range(3)), t_bits'($urandom_range(15)),
                                       t_bits'($urandom_range(15)), t_bits'($urandom_range(15)),
                                       t_bits'($urandom_range(15)));
            endcase
            send_idle_pct = send_pct_by_profile[ph % 4];
            stall_pct     = stall_pct_by_profile[ph % 4];
            // a handful of hot branches, some biased, some looping
            for (j = 0; j < 8; j++) begin
                hot_pc[j]     = $urandom;
                hot_bias[j]   = $urandom_range(100);
                hot_period[j] = ($urandom_range(3) == 0) ? $urandom_range(5, 2) : 0;
                hot_iter[j]   = 0;
            end
            // receiver holds off while the sender keeps pushing
            if (ph == 0) hold_cycles = 250;
            for (n = 0; n < 92; n++) begin
                if (ph == 6 && n == 46) drain();
                k = $urandom_range(7);
                if ($urandom_range(99) < 80) begin
                    br.branch_address = hot_pc[k];
                    if (hot_period[k] != 0) begin
                        br.taken = (hot_iter[k] % hot_period[k]) != 0;
                    end else begin
                        br.taken = $urandom_range(99) < hot_bias[k];
                    end
                    hot_iter[k]++;
                end else begin
                    br.branch_address = $urandom;
                    br.taken          = 1'($urandom_range(1));
                end
                send_branch(br);
            end
        end

        drain();
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
